/* src/tslfo_pkg.sv */
// ----------------------------------------------------------------------------
// tslfo_pkg
// Shared widths, register indexes and constants of the tempo-synced LFO.
// ----------------------------------------------------------------------------
`default_nettype none

package tslfo_pkg;

  localparam int FRAME_BITS_DEF = 48;

  localparam int MODE_W   = 2;
  localparam int SPEED_W  = 10;
  localparam int GAIN_W   = 18;
  localparam int OFFS_W   = 17;
  localparam int SRATE_W  = 18;
  localparam int TEMPO_W  = 17;
  localparam int LEVEL_W  = 17;
  localparam int DATA_W   = 18;
  localparam int INDEX_W  = 3;

  localparam int PROD1_W  = SPEED_W + SRATE_W;   // speed * sample rate
  localparam int SCALE_W  = 21;
  localparam int PERQ_W   = 49;                  // period in samples, Q16
  localparam int PERI_W   = PERQ_W - 16;         // integer period
  localparam int RAMP_W   = 17;
  localparam int WPROD_W  = LEVEL_W + GAIN_W;

  // 60 s/min * 100 centi * 256 (Q8 speed to Q16 period)
  localparam logic [SCALE_W-1:0] PERIOD_SCALE = 21'd1536000;
  localparam logic [TEMPO_W-1:0] DEFAULT_CENTI = 17'd12000;
  localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'd65536;

  typedef enum logic [INDEX_W-1:0] {
    REG_WAVE_MODE   = 3'd0,
    REG_SPEED       = 3'd1,
    REG_GAIN        = 3'd2,
    REG_OFFSET      = 3'd3,
    REG_SAMPLE_RATE = 3'd4
  } reg_index_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ZERO     = 2'd0,
    MODE_TRIANGLE = 2'd1,
    MODE_SAW      = 2'd2,
    MODE_SQUARE   = 2'd3
  } wave_mode_t;

endpackage

`default_nettype wire

/* src/tslfo_div.sv */
// ----------------------------------------------------------------------------
// tslfo_div
// Pipelined restoring divider: one quotient bit per stage, a starting
// remainder below the divisor, and a sideband word carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module tslfo_div
  import tslfo_pkg::*;
#(
  parameter int NB     = 17,
  parameter int DEN_W  = 17,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  rem_init,
  input  logic [NB-1:0]     num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [NB-1:0]     quo,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] out_side
);

  logic [NB-1:0]     v_q;
  logic [DEN_W-1:0]  r_q [NB];
  logic [NB-1:0]     q_q [NB];
  logic [DEN_W-1:0]  d_q [NB];
  logic [SIDE_W-1:0] s_q [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic              v_in;
    logic [DEN_W-1:0]  r_in;
    logic [DEN_W-1:0]  d_in;
    logic [NB-1:0]     q_in;
    logic [SIDE_W-1:0] s_in;
    logic [DEN_W:0]    sh;
    logic [DEN_W:0]    diff;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign r_in = rem_init;
      assign d_in = den;
      assign q_in = num;
      assign s_in = side;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
      assign q_in = q_q[k-1];
      assign s_in = s_q[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign sh   = {r_in, q_in[NB-1]};
    assign diff = sh - {1'b0, d_in};
    assign take = sh >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      r_q[k] <= take ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      q_q[k] <= {q_in[NB-2:0], take};
      d_q[k] <= d_in;
      s_q[k] <= s_in;
    end
  end

  assign out_valid = v_q[NB-1];
  assign quo       = q_q[NB-1];
  assign rem       = r_q[NB-1];
  assign out_side  = s_q[NB-1];

endmodule

`default_nettype wire

/* src/tempo_synced_lfo_top.sv */
// ----------------------------------------------------------------------------
// tempo_synced_lfo_top
// Tempo-synced LFO: period from tempo, speed and sample rate; phase is the
// frame position modulo the period; zero, triangle, saw or square, scaled,
// offset and clamped to 0..1.0 in Q16.
// Pipeline: 49-stage period divider, FRAME_BITS-stage modulo, 17-stage ramp
//   divider and six single stages.
// Throughput: one word per cycle; busy is always low.
// A stopped transport (is_playing low) is taken and gives no result.
// Reset (rst, synchronous) empties the pipeline and loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tempo_synced_lfo_top
  import tslfo_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  wr_en,
  input  logic [INDEX_W-1:0]    wr_index,
  input  logic [DATA_W-1:0]     wr_data,
  // input word
  input  logic                  start,
  output logic                  busy,
  input  logic [FRAME_BITS-1:0] frame_pos,
  input  logic                  is_playing,
  input  logic                  tempo_valid,
  input  logic [TEMPO_W-1:0]    tempo_centi_bpm,
  // result word
  output logic                  done,
  output logic [LEVEL_W-1:0]    lfo_level
);

  // ---------------- configuration registers ----------------
  logic [MODE_W-1:0]  wave_mode;
  logic [SPEED_W-1:0] speed_q8;
  logic [GAIN_W-1:0]  gain_q16;
  logic [OFFS_W-1:0]  offset_q16;
  logic [SRATE_W-1:0] sample_rate_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode      <= MODE_TRIANGLE;
      speed_q8       <= 10'd256;
      gain_q16       <= 18'd65536;
      offset_q16     <= '0;
      sample_rate_hz <= 18'd48000;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_WAVE_MODE:   wave_mode      <= wr_data[MODE_W-1:0];
        REG_SPEED:       speed_q8       <= wr_data[SPEED_W-1:0];
        REG_GAIN:        gain_q16       <= wr_data[GAIN_W-1:0];
        REG_OFFSET:      offset_q16     <= wr_data[OFFS_W-1:0];
        REG_SAMPLE_RATE: sample_rate_hz <= wr_data[SRATE_W-1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  // Every word is taken at once; a stopped transport simply carries no valid.
  assign busy = 1'b0;

  // ---------------- stage 1: pick tempo, speed * rate ----------------
  logic                  s1_valid;
  logic [FRAME_BITS-1:0] s1_frame;
  logic [TEMPO_W-1:0]    s1_centi;
  logic [PROD1_W-1:0]    s1_prod;
  logic [TEMPO_W-1:0]    centi_sel;

  always_comb begin
    centi_sel = tempo_valid ? tempo_centi_bpm : DEFAULT_CENTI;
    // a valid tempo of zero counts as one centi-bpm
    if (centi_sel == '0) begin
      centi_sel = TEMPO_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy && is_playing;
    end
  end

  always_ff @(posedge clk) begin
    s1_frame <= frame_pos;
    s1_centi <= centi_sel;
    s1_prod  <= PROD1_W'(speed_q8) * PROD1_W'(sample_rate_hz);
  end

  // ---------------- stage 2: full period numerator ----------------
  logic                  s2_valid;
  logic [FRAME_BITS-1:0] s2_frame;
  logic [TEMPO_W-1:0]    s2_centi;
  logic [PERQ_W-1:0]     s2_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_frame <= s1_frame;
    s2_centi <= s1_centi;
    s2_num   <= PERQ_W'(s1_prod) * PERQ_W'(PERIOD_SCALE);
  end

  // ---------------- period divider: numerator / centi-bpm ----------------
  logic                  d1_valid;
  logic [PERQ_W-1:0]     d1_quo;
  logic [FRAME_BITS-1:0] d1_frame;

  tslfo_div #(
    .NB     (PERQ_W),
    .DEN_W  (TEMPO_W),
    .SIDE_W (FRAME_BITS)
  ) u_period_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .rem_init  ('0),
    .num       (s2_num),
    .den       (s2_centi),
    .side      (s2_frame),
    .out_valid (d1_valid),
    .quo       (d1_quo),
    .rem       (),
    .out_side  (d1_frame)
  );

  // ---------------- stage 3: clamp the period ----------------
  logic                  s3_valid;
  logic [FRAME_BITS-1:0] s3_frame;
  logic [PERQ_W-1:0]     s3_perq;
  logic [PERI_W-1:0]     s3_peri;
  logic [PERQ_W-1:0]     perq_c;
  logic [PERI_W-1:0]     peri_c;

  always_comb begin
    perq_c = (d1_quo == '0) ? PERQ_W'(1) : d1_quo;
    peri_c = perq_c[PERQ_W-1:16];
    if (peri_c == '0) begin
      peri_c = PERI_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_frame <= d1_frame;
    s3_perq  <= perq_c;
    s3_peri  <= peri_c;
  end

  // ---------------- modulo divider: phase = frame mod period ----------------
  logic                      d2_valid;
  logic [PERI_W-1:0]         d2_phase;
  logic [PERQ_W+PERI_W-1:0]  d2_side;
  logic [PERQ_W-1:0]         d2_perq;
  logic [PERI_W-1:0]         d2_peri;

  tslfo_div #(
    .NB     (FRAME_BITS),
    .DEN_W  (PERI_W),
    .SIDE_W (PERQ_W + PERI_W)
  ) u_phase_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .rem_init  ('0),
    .num       (s3_frame),
    .den       (s3_peri),
    .side      ({s3_perq, s3_peri}),
    .out_valid (d2_valid),
    .quo       (),
    .rem       (d2_phase),
    .out_side  (d2_side)
  );

  assign d2_perq = d2_side[PERQ_W+PERI_W-1:PERI_W];
  assign d2_peri = d2_side[PERI_W-1:0];

  // square is high while the phase is at most half the period
  logic sq_high;
  assign sq_high = d2_phase <= (d2_peri >> 1);

  // ---------------- ramp divider: 2 * phase / period in Q16 ----------------
  logic              d3_valid;
  logic [RAMP_W-1:0] d3_ramp;
  logic              d3_sq;

  tslfo_div #(
    .NB     (RAMP_W),
    .DEN_W  (PERQ_W),
    .SIDE_W (1)
  ) u_ramp_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d2_valid),
    .rem_init  ({d2_phase, 16'd0}),
    .num       ('0),
    .den       (d2_perq),
    .side      (sq_high),
    .out_valid (d3_valid),
    .quo       (d3_ramp),
    .rem       (),
    .out_side  (d3_sq)
  );

  // ---------------- stage 4: shape the wave ----------------
  logic               s4_valid;
  logic [LEVEL_W-1:0] s4_wave;
  logic [LEVEL_W-1:0] wave_c;

  always_comb begin
    unique case (wave_mode_t'(wave_mode))
      MODE_TRIANGLE: wave_c = (d3_ramp >= ONE_Q16) ? d3_ramp - ONE_Q16 : ONE_Q16 - d3_ramp;
      MODE_SAW:      wave_c = d3_ramp >> 1;
      MODE_SQUARE:   wave_c = d3_sq ? ONE_Q16 : '0;
      default:       wave_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s4_wave <= wave_c;
  end

  // ---------------- stage 5: apply gain ----------------
  logic               s5_valid;
  logic [WPROD_W-1:0] s5_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_prod <= WPROD_W'(s4_wave) * WPROD_W'(gain_q16);
  end

  // ---------------- stage 6: add offset, saturate, present ----------------
  logic [WPROD_W-16:0] level_sum;

  assign level_sum = (WPROD_W-15)'(s5_prod[WPROD_W-1:16]) + (WPROD_W-15)'(offset_q16);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    lfo_level <= (level_sum > (WPROD_W-15)'(ONE_Q16)) ? ONE_Q16 : level_sum[LEVEL_W-1:0];
  end

  // ---------------- assertions ----------------
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    done |-> lfo_level <= ONE_Q16)
    else $error("lfo_level above 1.0");

  a_stopped_drops: assert property (@(posedge clk) disable iff (rst)
    (start && !is_playing) |=> !s1_valid)
    else $error("stopped transport entered the pipeline");

  a_gain_follows: assert property (@(posedge clk) disable iff (rst)
    s4_valid |=> s5_valid)
    else $error("gain stage lost a word");

endmodule

`default_nettype wire

/* tb/tempo_synced_lfo_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tempo_synced_lfo_top_tb
// Drives transport words through the tempo-synced LFO across several register
// settings, predicts each level in fixed point and checks every done word
// against the oldest prediction, in order.
// ----------------------------------------------------------------------------

class lfo_scoreboard;
  logic [16:0] level_q[$];
  int          errors;

  function new();
    errors = 0;
  endfunction

  // note the level an accepted word will give
  function void note(logic [16:0] lvl);
    level_q.push_back(lvl);
  endfunction

  function void check(logic [16:0] got);
    logic [16:0] want;
    if (level_q.size() == 0) begin
      $display("%0t: unexpected lfo_level %0d", $time, got);
      errors++;
      return;
    end
    want = level_q.pop_front();
    if (got !== want) begin
      $display("%0t: lfo_level expected %0d actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tempo_synced_lfo_top_tb;
  import tslfo_pkg::*;

  localparam int FB      = FRAME_BITS_DEF;
  localparam int LATENCY = FB + 72;
  localparam int WATCHDOG = 20000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                wr_en = 1'b0;
  logic [INDEX_W-1:0]  wr_index = '0;
  logic [DATA_W-1:0]   wr_data = '0;
  logic                start = 1'b0;
  logic                busy;
  logic [FB-1:0]       frame_pos = '0;
  logic                is_playing = 1'b0;
  logic                tempo_valid = 1'b0;
  logic [TEMPO_W-1:0]  tempo_centi_bpm = '0;
  logic                done;
  logic [LEVEL_W-1:0]  lfo_level;

  // predictor copy of the registers
  logic [1:0]  mode_r;
  logic [9:0]  speed_r;
  logic [17:0] gain_r;
  logic [16:0] offset_r;
  logic [17:0] srate_r;

  lfo_scoreboard sb = new();
  int idle_cycles = 0;

  tempo_synced_lfo_top #(.FRAME_BITS(FB)) dut (.*);

  always #10 clk = ~clk;

  // check every done word; count stalled cycles for the watchdog
  always @(posedge clk) begin
    if (!rst && done) sb.check(lfo_level);
    if (!rst && ((start && !busy) || done)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("tempo_synced_lfo_top_tb: FAIL");
      $finish;
    end
  end

  // compute the expected level of one playing word
  function automatic logic [16:0] lfo_predict(logic [FB-1:0] frame, logic tv,
                                              logic [16:0] centi_in);
    logic [63:0] centi, per_q, per_i, phase, r, q, wave, lvl;
    centi = tv ? {47'd0, centi_in} : 64'd12000;
    if (centi == 64'd0) centi = 64'd1;
    per_q = (64'(speed_r) * 64'(srate_r) * 64'd1536000) / centi;
    if (per_q == 64'd0) per_q = 64'd1;
    per_i = per_q >> 16;
    if (per_i == 64'd0) per_i = 64'd1;
    phase = 64'(frame) % per_i;
    // long division: floor(phase * 2^33 / per_q)
    r = phase << 16;
    q = 64'd0;
    for (int i = 0; i < 17; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= per_q) begin
        r = r - per_q;
        q[0] = 1'b1;
      end
    end
    case (wave_mode_t'(mode_r))
      MODE_TRIANGLE: wave = (q >= 64'd65536) ? q - 64'd65536 : 64'd65536 - q;
      MODE_SAW:      wave = q >> 1;
      MODE_SQUARE:   wave = (phase <= per_i / 2) ? 64'd65536 : 64'd0;
      default:       wave = 64'd0;
    endcase
    lvl = ((wave * 64'(gain_r)) >> 16) + 64'(offset_r);
    if (lvl > 64'd65536) lvl = 64'd65536;
    return lvl[16:0];
  endfunction

  task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    case (idx)
      REG_WAVE_MODE:   mode_r = val[1:0];
      REG_SPEED:       speed_r = val[9:0];
      REG_GAIN:        gain_r = val;
      REG_OFFSET:      offset_r = val[16:0];
      REG_SAMPLE_RATE: srate_r = val;
      default: ;
    endcase
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  // program all five registers, one write after another
  task automatic set_all(logic [1:0] m, logic [9:0] s, logic [17:0] g,
                         logic [16:0] o, logic [17:0] sr);
    write_reg(REG_WAVE_MODE, DATA_W'(m));
    write_reg(REG_SPEED, DATA_W'(s));
    write_reg(REG_GAIN, g);
    write_reg(REG_OFFSET, DATA_W'(o));
    write_reg(REG_SAMPLE_RATE, sr);
  endtask

  // send one word, with an optional gap before it; start stays high after
  // the accepting edge so that a following word with no gap goes back to back
  task automatic send_word(logic [FB-1:0] f, logic p, logic tv, logic [16:0] c,
                           int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    frame_pos <= f;
    is_playing <= p;
    tempo_valid <= tv;
    tempo_centi_bpm <= c;
    do @(posedge clk); while (busy);
    if (p) sb.note(lfo_predict(f, tv, c));
  endtask

  // drop start, wait for every expected word, then let stopped words drain
  task automatic drain();
    start <= 1'b0;
    while (sb.level_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [FB-1:0] rand_frame();
    logic [FB-1:0] f;
    f = FB'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: f = f & 48'hFFFF;
      1: f = f & 48'hFF_FFFF;
      default: ;
    endcase
    return f;
  endfunction

  task automatic random_phase(int n, logic chaotic);
    for (int i = 0; i < n; i++) begin
      logic [16:0] c;
      c = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(1, 100000));
      send_word(rand_frame(), $urandom_range(0, 7) != 0, $urandom_range(0, 3) != 0, c,
                chaotic ? $urandom_range(0, 19) : 0);
    end
  endtask

  initial begin
    mode_r = MODE_TRIANGLE;
    speed_r = 10'd256;
    gain_r = 18'd65536;
    offset_r = 17'd0;
    srate_r = 18'd48000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes of frame and tempo, stopped transport, each mode
    send_word('0, 1'b1, 1'b0, 17'd0, 0);
    send_word('1, 1'b1, 1'b1, 17'd100000, 0);
    send_word(48'd12345, 1'b1, 1'b1, 17'd0, 0);        // tempo zero
    send_word(48'd777, 1'b1, 1'b1, 17'h1FFFF, 0);
    send_word(48'd24000, 1'b0, 1'b1, 17'd12000, 0);    // stopped, no word
    send_word(48'd24000, 1'b1, 1'b1, 17'd12000, 0);
    send_word(48'd11999, 1'b1, 1'b0, 17'd5, 3);
    drain();
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_WAVE_MODE, DATA_W'(m));
      send_word(48'd0, 1'b1, 1'b0, 17'd0, 0);
      send_word(48'd6000, 1'b1, 1'b0, 17'd0, 0);
      send_word(48'd12000, 1'b1, 1'b0, 17'd0, 0);
      send_word(48'd18000, 1'b1, 1'b0, 17'd0, 0);
      drain();
    end
    // period of 46 samples, then period zero, then the largest period
    set_all(MODE_SQUARE, 10'd25, 18'd131072, 17'd65536, 18'd8000);
    send_word(48'd99, 1'b1, 1'b1, 17'd100000, 0);
    drain();
    write_reg(REG_SPEED, 18'd0);
    send_word(48'd5, 1'b1, 1'b1, 17'd100, 0);
    drain();
    write_reg(REG_SAMPLE_RATE, 18'h3FFFF);
    write_reg(REG_SPEED, 18'h3FF);
    send_word('1, 1'b1, 1'b1, 17'd1, 0);
    drain();

    // random phases over several register settings, extremes included
    set_all(MODE_TRIANGLE, 10'd256, 18'd65536, 17'd0, 18'd48000);
    random_phase(120, 1'b1);
    drain();
    set_all(MODE_SAW, 10'd512, 18'd131072, 17'd0, 18'd192000);
    random_phase(120, 1'b0);
    drain();
    set_all(MODE_SQUARE, 10'd25, 18'd0, 17'd65536, 18'd8000);
    random_phase(80, 1'b1);
    drain();
    for (int k = 0; k < 4; k++) begin
      set_all(2'($urandom_range(0, 3)), 10'($urandom), 18'($urandom), 17'($urandom),
              18'($urandom));
      random_phase(95, k[0]);
      drain();
    end

    if (sb.errors == 0) begin
      $display("tempo_synced_lfo_top_tb: PASS");
    end else begin
      $display("tempo_synced_lfo_top_tb: FAIL");
    end
    $finish;
  end
endmodule
